### hdl/crs_pkg.sv
// Shared types, constants and fixed-point helpers for the Catmull-Rom spline unit.
// Used by the channel interfaces, the point RAM, the axis datapath and the top level.
package crs_pkg;

  localparam int COORD_W    = 32;
  localparam int PARAM_BITS = 16;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  // Wide enough for every Horner intermediate of the doubled basis.
  localparam int ACC_W      = 38;
  localparam int PROD_W     = ACC_W + PARAM_BITS + 1;
  localparam int LAST_STG   = 10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_POINTS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PARAM_BITS-1:0]     frac_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [LAST_STG:3]         dp_en_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  function automatic prod_t mul_f(acc_t x, frac_t f);
    return x * $signed({1'b0, f});
  endfunction

  // Round to nearest with ties toward positive infinity.
  function automatic acc_t round_f(prod_t p);
    prod_t t;
    t = p + (prod_t'(1) <<< (PARAM_BITS - 1));
    return acc_t'(t >>> PARAM_BITS);
  endfunction

  // Halve (rounding up on ties) and saturate to the coordinate width.
  function automatic coord_t sat_half(acc_t a);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] h;
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = {{(ACC_W + 1 - COORD_W){1'b0}}, 1'b0, {(COORD_W - 1){1'b1}}};
    lo = {{(ACC_W + 1 - COORD_W){1'b1}}, 1'b1, {(COORD_W - 1){1'b0}}};
    s  = (ACC_W + 1)'(a) + (ACC_W + 1)'(1);
    h  = s >>> 1;
    if (h > hi) begin
      return hi[COORD_W-1:0];
    end else if (h < lo) begin
      return lo[COORD_W-1:0];
    end
    return h[COORD_W-1:0];
  endfunction

endpackage

### hdl/crs_cmd_if.sv
// Request channel of the spline unit: valid/ready handshake and request payload.
// Depends on crs_pkg for the field types.
interface crs_cmd_if;
  logic              valid;
  logic              ready;
  logic              op;
  crs_pkg::idx_t     point_index;
  crs_pkg::coord_t   coord_x;
  crs_pkg::coord_t   coord_y;
  crs_pkg::coord_t   coord_z;
  crs_pkg::frac_t    global_t;

  modport source (output valid, op, point_index, coord_x, coord_y, coord_z, global_t,
                  input ready);
  modport sink   (input valid, op, point_index, coord_x, coord_y, coord_z, global_t,
                  output ready);
endinterface

### hdl/crs_res_if.sv
// Result channel of the spline unit: valid/ready handshake, position and tangent.
// Depends on crs_pkg for the field types.
interface crs_res_if;
  logic            valid;
  logic            ready;
  crs_pkg::coord_t pos_x;
  crs_pkg::coord_t pos_y;
  crs_pkg::coord_t pos_z;
  crs_pkg::coord_t deriv_x;
  crs_pkg::coord_t deriv_y;
  crs_pkg::coord_t deriv_z;

  modport source (output valid, pos_x, pos_y, pos_z, deriv_x, deriv_y, deriv_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, deriv_x, deriv_y, deriv_z,
                  output ready);
endinterface

### hdl/crs_ram.sv
// Control point store: four identical banks, each read at one neighbor address.
// Depends on crs_pkg for the point and index types.
module crs_ram (
  input  logic            clk,
  input  logic            we,
  input  crs_pkg::idx_t   waddr,
  input  crs_pkg::point_t wdata,
  input  logic            re,
  input  crs_pkg::idx_t   raddr [4],
  output crs_pkg::point_t rdata [4]
);
  import crs_pkg::*;

  // Every write goes to all banks, so each neighbor gets its own read port.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    point_t mem [MAX_POINTS];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (re) begin
        rdata[b] <= mem[raddr[b]];
      end
    end
  end

endmodule

### hdl/crs_axis.sv
// Datapath for one coordinate axis: basis coefficients, then Horner steps that
// alternate a registered multiply with a registered round-and-add. Depends on crs_pkg.
module crs_axis (
  input  logic            clk,
  input  crs_pkg::dp_en_t en,
  input  crs_pkg::coord_t p0,
  input  crs_pkg::coord_t p1,
  input  crs_pkg::coord_t p2,
  input  crs_pkg::coord_t p3,
  input  crs_pkg::frac_t  f2,
  output crs_pkg::coord_t pos,
  output crs_pkg::coord_t deriv
);
  import crs_pkg::*;

  acc_t  e0, e1, e2, e3;
  acc_t  a3, a3x3, a2, a2x2, a1_3, a0_3;
  frac_t f3, f4, f5, f6, f7;
  prod_t pr_p4, pr_d4, pr_p6, pr_d6, pr_p8;
  acc_t  a2_4, a2x2_4, a1_4, a0_4;
  acc_t  acc_p5, acc_d5, a1_5, a0_5;
  acc_t  a1_6, a0_6;
  acc_t  acc_p7, dfin7, a0_7;
  acc_t  dfin8, a0_8;
  acc_t  acc_p9, dfin9;

  assign e0 = acc_t'(p0);
  assign e1 = acc_t'(p1);
  assign e2 = acc_t'(p2);
  assign e3 = acc_t'(p3);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      a3   <= -e0 + 3 * e1 - 3 * e2 + e3;
      a3x3 <= -3 * e0 + 9 * e1 - 9 * e2 + 3 * e3;
      a2   <= 2 * e0 - 5 * e1 + 4 * e2 - e3;
      a2x2 <= 4 * e0 - 10 * e1 + 8 * e2 - 2 * e3;
      a1_3 <= e2 - e0;
      a0_3 <= 2 * e1;
      f3   <= f2;
    end
    if (en[4]) begin
      pr_p4  <= mul_f(a3, f3);
      pr_d4  <= mul_f(a3x3, f3);
      a2_4   <= a2;
      a2x2_4 <= a2x2;
      a1_4   <= a1_3;
      a0_4   <= a0_3;
      f4     <= f3;
    end
    if (en[5]) begin
      acc_p5 <= round_f(pr_p4) + a2_4;
      acc_d5 <= round_f(pr_d4) + a2x2_4;
      a1_5   <= a1_4;
      a0_5   <= a0_4;
      f5     <= f4;
    end
    if (en[6]) begin
      pr_p6 <= mul_f(acc_p5, f5);
      pr_d6 <= mul_f(acc_d5, f5);
      a1_6  <= a1_5;
      a0_6  <= a0_5;
      f6    <= f5;
    end
    if (en[7]) begin
      acc_p7 <= round_f(pr_p6) + a1_6;
      dfin7  <= round_f(pr_d6) + a1_6;
      a0_7   <= a0_6;
      f7     <= f6;
    end
    if (en[8]) begin
      pr_p8 <= mul_f(acc_p7, f7);
      dfin8 <= dfin7;
      a0_8  <= a0_7;
    end
    if (en[9]) begin
      acc_p9 <= round_f(pr_p8) + a0_8;
      dfin9  <= dfin8;
    end
    if (en[10]) begin
      pos   <= sat_half(acc_p9);
      deriv <= sat_half(dfin9);
    end
  end

endmodule

### hdl/catmull_rom_spline_eval_unit.sv
// Closed uniform Catmull-Rom spline evaluator.
// Depends on crs_pkg, crs_cmd_if, crs_res_if, crs_ram and crs_axis.
//
// Requests arrive on cmd. A request with op write stores one control point at
// point_index and gives no result. A request with op evaluate maps global_t onto
// the closed curve through the first points in use and gives one result on
// res: position and derivative with respect to local t, Q16.16, saturated.
// The point count is set through cfg_we/cfg_wdata; the user must write it only while
// the unit is idle, which the unit does not enforce; zero acts as one and values above 64 act as 64.
//
// The unit is a ten-stage pipeline and takes one request per clock cycle while res
// is not stalled. A result is presented on res from the last stage; the multiply,
// round and add steps of the Horner chains set the pipeline depth. Each stage advances
// when it is empty or the stage after it advances, so when res is stalled the unit
// keeps accepting requests until the bubbles are filled, and then holds everything
// without loss.
// Reset clears all stage valid bits and sets the point count to 4. The point
// table is not cleared; only points that have been written may be evaluated.
module catmull_rom_spline_eval_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_wdata,
  crs_cmd_if.sink              cmd,
  crs_res_if.source            res
);
  import crs_pkg::*;

  cnt_t   neff;
  logic   [LAST_STG+1:1] en;
  logic   [LAST_STG:1]   v;

  logic   op1;
  idx_t   pidx1;
  point_t pt1;
  cnt_t   seg1;
  frac_t  f1, f2;

  logic [CNT_W+PARAM_BITS-1:0] s;
  cnt_t   seg_raw, seg;
  cnt_t   idx [4];
  idx_t   raddr [4];
  point_t rdata [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      neff <= COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        neff <= CNT_W'(1);
      end else if (cfg_wdata > COUNT_MAX) begin
        neff <= COUNT_MAX;
      end else begin
        neff <= cfg_wdata;
      end
    end
  end

  always_comb begin
    en[LAST_STG+1] = res.ready;
    for (int k = LAST_STG; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign cmd.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= cmd.valid;
      end
      // Write requests end at the table; only evaluations go on.
      if (en[2]) begin
        v[2] <= v[1] && (op1 == OP_EVAL);
      end
      for (int k = 3; k <= LAST_STG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s       = (CNT_W + PARAM_BITS)'(cmd.global_t) * (CNT_W + PARAM_BITS)'(neff);
  assign seg_raw = s[CNT_W+PARAM_BITS-1:PARAM_BITS];
  assign seg     = (seg_raw >= neff) ? neff - CNT_W'(1) : seg_raw;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1   <= cmd.op;
      pidx1 <= cmd.point_index;
      pt1   <= '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
      seg1  <= seg;
      f1    <= s[PARAM_BITS-1:0];
    end
    if (en[2]) begin
      f2 <= f1;
    end
  end

  // Neighbor indices with wraparound on the closed curve.
  always_comb begin
    idx[0] = (seg1 == '0) ? neff - CNT_W'(1) : seg1 - CNT_W'(1);
    for (int k = 1; k < 4; k++) begin
      idx[k] = (idx[k-1] + CNT_W'(1) >= neff) ? '0 : idx[k-1] + CNT_W'(1);
    end
    for (int k = 0; k < 4; k++) begin
      raddr[k] = idx[k][IDX_W-1:0];
    end
  end

  crs_ram u_ram (
    .clk   (clk),
    .we    (en[2] && v[1] && (op1 == OP_WRITE)),
    .waddr (pidx1),
    .wdata (pt1),
    .re    (en[2]),
    .raddr (raddr),
    .rdata (rdata)
  );

  crs_axis u_axis_x (
    .clk   (clk),
    .en    (en[LAST_STG:3]),
    .p0    (rdata[0].x),
    .p1    (rdata[1].x),
    .p2    (rdata[2].x),
    .p3    (rdata[3].x),
    .f2    (f2),
    .pos   (res.pos_x),
    .deriv (res.deriv_x)
  );

  crs_axis u_axis_y (
    .clk   (clk),
    .en    (en[LAST_STG:3]),
    .p0    (rdata[0].y),
    .p1    (rdata[1].y),
    .p2    (rdata[2].y),
    .p3    (rdata[3].y),
    .f2    (f2),
    .pos   (res.pos_y),
    .deriv (res.deriv_y)
  );

  crs_axis u_axis_z (
    .clk   (clk),
    .en    (en[LAST_STG:3]),
    .p0    (rdata[0].z),
    .p1    (rdata[1].z),
    .p2    (rdata[2].z),
    .p3    (rdata[3].z),
    .f2    (f2),
    .pos   (res.pos_z),
    .deriv (res.deriv_z)
  );

  assign res.valid = v[LAST_STG];

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (en[2] && v[1] && (op1 == OP_WRITE)) |=> !v[2])
    else $error("write request entered the evaluation stages");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v[5] && !en[5]) |=> v[5])
    else $error("stalled stage lost its request");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> ((idx[0] < neff) && (idx[3] < neff)))
    else $error("neighbor index outside the points in use");
`endif

endmodule

### bench/catmull_rom_spline_eval_unit_tb.sv
// Self-checking testbench for catmull_rom_spline_eval_unit: predicts curve position and tangent
// for every evaluate request and compares them with the results. Depends on crs_pkg and on the
// crs_cmd_if and crs_res_if interfaces.
`timescale 1ns / 100ps

module catmull_rom_spline_eval_unit_tb;
  import crs_pkg::*;

  typedef struct {
    logic   op;
    idx_t   point_index;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    frac_t  global_t;
  } spline_req_t;

  typedef struct {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t deriv_x;
    coord_t deriv_y;
    coord_t deriv_z;
  } curve_pt_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  crs_cmd_if cmd_ch();
  crs_res_if res_ch();

  catmull_rom_spline_eval_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  spline_req_t req_queue[$];
  curve_pt_t   curve_queue[$];
  spline_req_t cur_req;

  // Predictor copy of the point tables and the count in use.
  coord_t tab_x [MAX_POINTS];
  coord_t tab_y [MAX_POINTS];
  coord_t tab_z [MAX_POINTS];
  int     pred_count;
  bit     gen_written [MAX_POINTS];
  int     gen_count;

  int  mismatches;
  bit  idle_on;
  bit  long_stall_go;
  bit  res_hold;
  int  send_gap;
  int  recv_gap;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint mul_round(longint x, longint f);
    return (x * f + 64'sd32768) >>> PARAM_BITS;
  endfunction

  function automatic coord_t halve_sat(longint x);
    longint v;
    v = (x + 1) >>> 1;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return coord_t'(v);
  endfunction

  task automatic spline_axis(input coord_t p0, input coord_t p1, input coord_t p2,
                             input coord_t p3, input longint f,
                             output coord_t pos, output coord_t der);
    longint a3, a2, a1, a0, acc;
    a3 = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
    a2 = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
    a1 = -longint'(p0) + longint'(p2);
    a0 = 2 * longint'(p1);
    acc = mul_round(a3, f) + a2;
    acc = mul_round(acc, f) + a1;
    acc = mul_round(acc, f) + a0;
    pos = halve_sat(acc);
    acc = mul_round(3 * a3, f) + 2 * a2;
    acc = mul_round(acc, f) + a1;
    der = halve_sat(acc);
  endtask

  // Applies one accepted request to the predictor and queues any expected result.
  task automatic apply_request(input spline_req_t r);
    longint    s, f;
    int        seg;
    int        idx [4];
    curve_pt_t e;
    if (r.op == OP_WRITE) begin
      tab_x[r.point_index] = r.cx;
      tab_y[r.point_index] = r.cy;
      tab_z[r.point_index] = r.cz;
    end else begin
      s = longint'(r.global_t) * pred_count;
      seg = int'(s >> PARAM_BITS);
      f = s & 64'hFFFF;
      if (seg >= pred_count) seg = pred_count - 1;
      idx[0] = (seg == 0) ? pred_count - 1 : seg - 1;
      for (int k = 1; k < 4; k++) idx[k] = (idx[k-1] + 1 >= pred_count) ? 0 : idx[k-1] + 1;
      spline_axis(tab_x[idx[0]], tab_x[idx[1]], tab_x[idx[2]], tab_x[idx[3]], f,
                  e.pos_x, e.deriv_x);
      spline_axis(tab_y[idx[0]], tab_y[idx[1]], tab_y[idx[2]], tab_y[idx[3]], f,
                  e.pos_y, e.deriv_y);
      spline_axis(tab_z[idx[0]], tab_z[idx[1]], tab_z[idx[2]], tab_z[idx[3]], f,
                  e.pos_z, e.deriv_z);
      curve_queue.push_back(e);
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        apply_request(cur_req);
        send_gap = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.op          <= cur_req.op;
          cmd_ch.point_index <= cur_req.point_index;
          cmd_ch.coord_x     <= cur_req.cx;
          cmd_ch.coord_y     <= cur_req.cy;
          cmd_ch.coord_z     <= cur_req.cz;
          cmd_ch.global_t    <= cur_req.global_t;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(input string name, input coord_t exp_v, input coord_t act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on %s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  // Result monitor and receiver.
  always @(posedge clk) begin
    curve_pt_t e;
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (curve_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result with no request pending");
        end else begin
          e = curve_queue.pop_front();
          report("pos_x", e.pos_x, res_ch.pos_x);
          report("pos_y", e.pos_y, res_ch.pos_y);
          report("pos_z", e.pos_z, res_ch.pos_z);
          report("deriv_x", e.deriv_x, res_ch.deriv_x);
          report("deriv_y", e.deriv_y, res_ch.deriv_y);
          report("deriv_z", e.deriv_z, res_ch.deriv_z);
        end
        recv_gap = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (res_hold) begin
        res_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps going, so the pipeline backs up.
  initial begin : long_hold_off
    res_hold = 1'b0;
    wait (long_stall_go);
    @(negedge clk);
    res_hold = 1'b1;
    repeat (300) @(negedge clk);
    res_hold = 1'b0;
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  function automatic spline_req_t point_write(int i, coord_t x, coord_t y, coord_t z);
    spline_req_t r;
    r.op = OP_WRITE;
    r.point_index = idx_t'(i);
    r.cx = x;
    r.cy = y;
    r.cz = z;
    r.global_t = frac_t'($urandom);
    gen_written[i] = 1'b1;
    return r;
  endfunction

  // Evaluations are only generated once every point in use has been written.
  function automatic spline_req_t curve_eval(frac_t g);
    spline_req_t r;
    for (int i = 0; i < gen_count; i++)
      if (!gen_written[i]) return point_write(i, pick_coord(), pick_coord(), pick_coord());
    r.op = OP_EVAL;
    r.point_index = idx_t'($urandom);
    r.cx = coord_t'($urandom);
    r.cy = coord_t'($urandom);
    r.cz = coord_t'($urandom);
    r.global_t = g;
    return r;
  endfunction

  task automatic set_curve_size(input int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_count = (v == 0) ? 1 : (v > MAX_POINTS) ? MAX_POINTS : v;
    gen_count  = pred_count;
  endtask

  task automatic drain();
    while (req_queue.size() > 0 || cmd_ch.valid || curve_queue.size() > 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    frac_t g;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < 30) begin
        req_queue.push_back(point_write($urandom_range(0, MAX_POINTS - 1),
                                        pick_coord(), pick_coord(), pick_coord()));
      end else begin
        case ($urandom_range(0, 3))
          0: g = frac_t'(($urandom_range(0, gen_count) * 65536) / gen_count
                         + int'($urandom_range(0, 2)) - 1);
          default: g = frac_t'($urandom);
        endcase
        req_queue.push_back(curve_eval(g));
      end
    end
  endtask

  initial begin : stimulus
    int cfg_list [10] = '{0, 1, 64, 127, 2, 3, 37, 65, 4, 100};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_on = 1'b1;
    long_stall_go = 1'b0;
    mismatches = 0;
    pred_count = 4;
    gen_count = 4;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_WRITE;
    cmd_ch.point_index = '0;
    cmd_ch.coord_x = '0;
    cmd_ch.coord_y = '0;
    cmd_ch.coord_z = '0;
    cmd_ch.global_t = '0;
    res_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extreme coordinates and parameters at segment edges.
    set_curve_size(4);
    req_queue.push_back(point_write(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000));
    req_queue.push_back(point_write(1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1));
    req_queue.push_back(point_write(2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000));
    req_queue.push_back(point_write(3, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh0001_0000));
    req_queue.push_back(point_write(63, 32'sh1234_5678, -32'sh1, 32'sh7FFF_FFFF));
    req_queue.push_back(curve_eval(16'h0000));
    req_queue.push_back(curve_eval(16'h0001));
    req_queue.push_back(curve_eval(16'h3FFF));
    req_queue.push_back(curve_eval(16'h4000));
    req_queue.push_back(curve_eval(16'h8000));
    req_queue.push_back(curve_eval(16'hBFFF));
    req_queue.push_back(curve_eval(16'hFFFF));
    req_queue.push_back(point_write(2, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000));
    req_queue.push_back(curve_eval(16'h2000));
    req_queue.push_back(curve_eval(16'hE000));
    drain();

    for (int p = 0; p < 10; p++) begin
      set_curve_size(cfg_list[p]);
      idle_on = (p % 3 != 2);
      if (p == 3) begin
        @(negedge clk);
        idle_on = 1'b0;
        long_stall_go = 1'b1;
      end
      random_phase(p == 9 ? 1600 / 10 : 175);
      // Sender pause: everything drains before the register changes.
      drain();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
hdl/crs_pkg.sv
hdl/crs_cmd_if.sv
hdl/crs_res_if.sv
hdl/crs_ram.sv
hdl/crs_axis.sv
hdl/catmull_rom_spline_eval_unit.sv
bench/catmull_rom_spline_eval_unit_tb.sv
